/* hw/rtl/ipv4_prefix_match_table_top_macros.svh */
// ============================================================================
// ipv4_prefix_match_table_top_macros.svh
// assertion macros shared by the prefix table rtl
// ============================================================================
`ifndef IPV4_PREFIX_MATCH_TABLE_TOP_MACROS_SVH
`define IPV4_PREFIX_MATCH_TABLE_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PFXM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pfxm assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define PFXM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pfxm assertion failed");

`endif

/* hw/rtl/pfxm_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// pfxm_pkg
// shared types, codes and helpers of the ipv4 prefix match table
// ============================================================================
package pfxm_pkg;

    localparam int ENTRIES    = 64;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_BITS  = 32;
    localparam int LEN_BITS   = 6;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_ABSENT  = 2'd2;
    localparam logic [1:0] STAT_SAT     = 2'd3;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [ADDR_BITS-1:0] address;
        logic [LEN_BITS-1:0]  prefix_len;
    } t_in_req;

    typedef struct packed {
        logic       matched;
        logic [1:0] status;
    } t_out_res;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  value;
        logic [LEN_BITS-1:0]   len;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             live;
        t_entry           entry;
    } t_tbl_rd;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             live;
        t_entry           entry;
    } t_tbl_wr;

    // length is at most ADDR_BITS here; a shift by the full width gives zero
    function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_BITS-1:0] len);
        return ~({ADDR_BITS{1'b1}} >> len);
    endfunction

    function automatic logic [LEN_BITS-1:0] sat_len(input logic [LEN_BITS-1:0] len);
        return (len > LEN_BITS'(ADDR_BITS)) ? LEN_BITS'(ADDR_BITS) : len;
    endfunction

endpackage

/* hw/rtl/pfxm_table.sv */
`timescale 1ns / 1ps
// ============================================================================
// pfxm_table
// prefix entry memory with one read and one write port, plus live bits
// ============================================================================
module pfxm_table (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [pfxm_pkg::IDX_W-1:0] i_rd_idx,
    input  pfxm_pkg::t_tbl_wr       i_wr,
    output pfxm_pkg::t_tbl_rd       o_rd
);

    pfxm_pkg::t_entry                 r_mem [pfxm_pkg::ENTRIES];
    logic [pfxm_pkg::ENTRIES-1:0]     r_live;
    pfxm_pkg::t_entry                 r_rd_entry;
    logic [pfxm_pkg::IDX_W-1:0]       r_rd_idx;
    logic                             r_rd_vld;
    logic                             r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
        r_rd_entry <= r_mem[i_rd_idx];
        r_rd_idx   <= i_rd_idx;
    end

    // a slot is live while its count is nonzero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_vld  <= i_rd_en;
            r_rd_live <= r_live[i_rd_idx];
            if (i_wr.en) begin
                r_live[i_wr.idx] <= i_wr.live;
            end
        end
    end

    assign o_rd = '{vld: r_rd_vld, idx: r_rd_idx, live: r_rd_live, entry: r_rd_entry};

endmodule

/* hw/rtl/pfxm_cmp.sv */
`timescale 1ns / 1ps
// ============================================================================
// pfxm_cmp
// shared compare unit: key match for insert and remove, cover test for query
// ============================================================================
module pfxm_cmp (
    input  logic [1:0]                     i_cmd,
    input  logic [pfxm_pkg::ADDR_BITS-1:0] i_addr,
    input  logic [pfxm_pkg::ADDR_BITS-1:0] i_value,
    input  logic [pfxm_pkg::LEN_BITS-1:0]  i_len,
    input  pfxm_pkg::t_tbl_rd              i_rd,
    output logic                           o_hit,
    output logic                           o_free
);

    logic w_key_eq;
    logic w_cover;

    assign w_key_eq = (i_rd.entry.len == i_len) && (i_rd.entry.value == i_value);
    assign w_cover  = ((i_addr & pfxm_pkg::len_mask(i_rd.entry.len)) == i_rd.entry.value);

    assign o_hit  = i_rd.vld && i_rd.live &&
                    ((i_cmd == pfxm_pkg::CMD_QUERY) ? w_cover : w_key_eq);
    assign o_free = i_rd.vld && !i_rd.live;

endmodule

/* hw/rtl/ipv4_prefix_match_table_top.sv */
`timescale 1ns / 1ps
`include "ipv4_prefix_match_table_top_macros.svh"
// ============================================================================
// ipv4_prefix_match_table_top
// reference-counted ipv4 prefix table with insert, remove and cover query
// ============================================================================
// usage:
//   request channel i_in_valid / o_in_stall carries cmd, address, prefix_len;
//   result channel o_out_valid / i_out_stall carries matched and status.
//   a request is taken only while the block is idle, then one table slot
//   is read and compared per cycle through a single memory read port and
//   one compare unit, for all 64 slots.
//   the block takes no new request until the scan over all slots, the
//   decision and the hand-off of the result to the output register are
//   done.
//   the result sits in an output register, so a finished result may wait
//   there while the block is idle again and takes the next request; a
//   second result waits in the sequencer until the register is free.
//   reset clears the live bits, so the table starts empty; no clearing
//   pass is needed.
// ============================================================================
module ipv4_prefix_match_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pfxm_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pfxm_pkg::t_out_res o_out_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_FINISH
    } t_state;

    t_state                               r_state;
    logic [1:0]                           r_cmd;
    logic [pfxm_pkg::ADDR_BITS-1:0]       r_addr;
    logic [pfxm_pkg::ADDR_BITS-1:0]       r_value;
    logic [pfxm_pkg::LEN_BITS-1:0]        r_len;
    logic [pfxm_pkg::IDX_W-1:0]           r_scan;
    logic                                 r_hit;
    logic [pfxm_pkg::IDX_W-1:0]           r_hit_idx;
    logic [pfxm_pkg::COUNT_BITS-1:0]      r_hit_cnt;
    logic                                 r_free;
    logic [pfxm_pkg::IDX_W-1:0]           r_free_idx;
    pfxm_pkg::t_out_res                   r_res;
    logic                                 r_out_valid;
    pfxm_pkg::t_out_res                   r_out_res;

    logic                                 in_accept;
    logic [pfxm_pkg::LEN_BITS-1:0]        in_len;
    pfxm_pkg::t_tbl_rd                    tbl_rd;
    pfxm_pkg::t_tbl_wr                    tbl_wr;
    pfxm_pkg::t_out_res                   n_res;
    logic                                 cmp_hit;
    logic                                 cmp_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_len      = pfxm_pkg::sat_len(i_in_req.prefix_len);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    pfxm_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (r_state == S_SCAN),
        .i_rd_idx (r_scan),
        .i_wr     (tbl_wr),
        .o_rd     (tbl_rd)
    );

    pfxm_cmp u_cmp (
        .i_cmd   (r_cmd),
        .i_addr  (r_addr),
        .i_value (r_value),
        .i_len   (r_len),
        .i_rd    (tbl_rd),
        .o_hit   (cmp_hit),
        .o_free  (cmp_free)
    );

    // table update and answer, from what the scan found
    always_comb begin
        tbl_wr             = '0;
        tbl_wr.idx         = r_hit_idx;
        tbl_wr.live        = 1'b1;
        tbl_wr.entry.value = r_value;
        tbl_wr.entry.len   = r_len;
        tbl_wr.entry.count = r_hit_cnt + pfxm_pkg::COUNT_BITS'(1);
        n_res              = '{matched: 1'b0, status: pfxm_pkg::STAT_OK};
        case (r_cmd)
            pfxm_pkg::CMD_INSERT: begin
                if (r_hit) begin
                    if (&r_hit_cnt) begin
                        n_res.status = pfxm_pkg::STAT_SAT;
                    end else begin
                        tbl_wr.en = 1'b1;
                    end
                end else if (r_free) begin
                    tbl_wr.en          = 1'b1;
                    tbl_wr.idx         = r_free_idx;
                    tbl_wr.entry.count = pfxm_pkg::COUNT_BITS'(1);
                end else begin
                    n_res.status = pfxm_pkg::STAT_FULL;
                end
            end
            pfxm_pkg::CMD_REMOVE: begin
                if (r_hit) begin
                    tbl_wr.en          = 1'b1;
                    tbl_wr.entry.count = r_hit_cnt - pfxm_pkg::COUNT_BITS'(1);
                    tbl_wr.live        = (r_hit_cnt != pfxm_pkg::COUNT_BITS'(1));
                end else begin
                    n_res.status = pfxm_pkg::STAT_ABSENT;
                end
            end
            pfxm_pkg::CMD_QUERY: begin
                n_res.matched = r_hit;
            end
            default: begin
            end
        endcase
        if (r_state != S_DECIDE) begin
            tbl_wr.en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_FINISH the output register is handled by the state below
            if (!i_out_stall && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            // first hit and lowest free slot win
            if (cmp_hit && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= tbl_rd.idx;
                r_hit_cnt <= tbl_rd.entry.count;
            end
            if (cmp_free && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= tbl_rd.idx;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd   <= i_in_req.cmd;
                        r_addr  <= i_in_req.address;
                        r_len   <= in_len;
                        r_value <= i_in_req.address & pfxm_pkg::len_mask(in_len);
                        r_scan  <= '0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + pfxm_pkg::IDX_W'(1);
                    if (r_scan == pfxm_pkg::IDX_W'(pfxm_pkg::ENTRIES - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_res   <= n_res;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PFXM_ASSERT_NXT(a_accept_starts_scan, in_accept, r_state == S_SCAN && r_scan == '0)
    `PFXM_ASSERT_IMP(a_write_only_decide, tbl_wr.en, r_state == S_DECIDE)
    `PFXM_ASSERT_IMP(a_match_only_query, r_state == S_FINISH && r_cmd != pfxm_pkg::CMD_QUERY, !r_res.matched)
    `PFXM_ASSERT_IMP(a_full_means_no_slot, r_state == S_FINISH && r_res.status == pfxm_pkg::STAT_FULL, !r_free && !r_hit)

endmodule
